@@ hdl/mbep_pkg.sv @@
// Shared types and constants for the masked best entry pop block.
package mbep_pkg;

    localparam int DATA_W    = 32;
    localparam int ENTRY_W   = 2 * DATA_W;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LARGEST = 2'd1;

    localparam logic [DATA_W-1:0] ID_EMPTY = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] KEY_ZERO = 32'h0000_0000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_POP   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_WRITE,
        ST_SCAN,
        ST_POP_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic sample;
    } best_ctl_t;

    typedef struct packed {
        logic               found;
        logic [DATA_W-1:0]  id;
        logic [DATA_W-1:0]  key;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

@@ hdl/mbep_ram.sv @@
// Generic single-port RAM with registered read data.
module mbep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mbep_best.sv @@
// Running best-entry tracker fed by the scan read stream.
module mbep_best #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbep_pkg::best_ctl_t            ctl,
    input  logic                           select_largest,
    input  logic [$clog2(MAX_ENTRIES)-1:0] cand_idx,
    input  logic [mbep_pkg::ENTRY_W-1:0]   cand,
    output logic                           have,
    output logic [$clog2(MAX_ENTRIES)-1:0] win_idx,
    output logic [mbep_pkg::DATA_W-1:0]    best_id,
    output logic [mbep_pkg::DATA_W-1:0]    best_key
);
    import mbep_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    logic              have_reg, have_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] id_reg, id_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] cand_id;
    logic [DATA_W-1:0] cand_key;
    logic              cand_valid;
    logic              better;

    assign cand_id    = cand[ENTRY_W-1:DATA_W];
    assign cand_key   = cand[DATA_W-1:0];
    assign cand_valid = !cand_id[DATA_W-1];

    // Ties go to the later slot, so equal keys replace the current best.
    always_comb
    begin
        if (select_largest)
        begin
            better = $signed(cand_key) >= $signed(key_reg);
        end
        else
        begin
            better = $signed(cand_key) <= $signed(key_reg);
        end
    end

    always_comb
    begin
        have_next = have_reg;
        idx_next  = idx_reg;
        id_next   = id_reg;
        key_next  = key_reg;
        if (ctl.clr)
        begin
            have_next = 1'b0;
        end
        else if (ctl.sample && cand_valid && (!have_reg || better))
        begin
            have_next = 1'b1;
            idx_next  = cand_idx;
            id_next   = cand_id;
            key_next  = cand_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign have     = have_reg;
    assign win_idx  = idx_reg;
    assign best_id  = id_reg;
    assign best_key = key_reg;

endmodule

@@ hdl/mbep_ctrl.sv @@
// Sequencer: clearing pass, slot read-modify-write, pop scan and valid count.
module mbep_ctrl #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           mode,
    input  logic [5:0]                     slot_index,
    input  logic [mbep_pkg::DATA_W-1:0]    entry_id,
    input  logic [mbep_pkg::DATA_W-1:0]    entry_key,
    input  logic [mbep_pkg::CFG_DAT_W-1:0] entries_in_use,
    output logic                           idle,
    output logic                           ram_we,
    output logic [$clog2(MAX_ENTRIES)-1:0] ram_addr,
    output logic [mbep_pkg::ENTRY_W-1:0]   ram_wdata,
    input  logic [mbep_pkg::ENTRY_W-1:0]   ram_rdata,
    output mbep_pkg::best_ctl_t            best_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0] cand_idx,
    input  logic                           best_have,
    input  logic [$clog2(MAX_ENTRIES)-1:0] win_idx,
    input  logic [mbep_pkg::DATA_W-1:0]    best_id,
    input  logic [mbep_pkg::DATA_W-1:0]    best_key,
    output logic                           res_valid,
    output mbep_pkg::result_t              result,
    input  logic                           res_take
);
    import mbep_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]     scan_len_reg, scan_len_next;
    logic [CW-1:0]     issue_cnt_reg, issue_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              slot_ok_reg, slot_ok_next;
    logic [DATA_W-1:0] id_reg, id_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] res_id_reg, res_id_next;
    logic [DATA_W-1:0] res_key_reg, res_key_next;
    logic [CW-1:0]     scan_len;
    logic              was_valid;
    logic              now_valid;

    assign scan_len  = (32'(entries_in_use) > MAX_ENTRIES) ? COUNT_MAX : CW'(entries_in_use);
    assign was_valid = !ram_rdata[ENTRY_W-1];
    assign now_valid = !id_reg[DATA_W-1];

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_len_next  = scan_len_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        slot_ok_next   = slot_ok_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        res_id_next    = res_id_reg;
        res_key_next   = res_key_reg;
        ram_we         = 1'b0;
        ram_addr       = slot_reg;
        ram_wdata      = {id_reg, key_reg};
        best_ctl       = '0;
        idle           = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = {ID_EMPTY, KEY_ZERO};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                idle = 1'b1;
                if (accept)
                begin
                    slot_next      = AW'(slot_index);
                    slot_ok_next   = 32'(slot_index) < MAX_ENTRIES;
                    id_next        = entry_id;
                    key_next       = entry_key;
                    found_next     = 1'b0;
                    res_id_next    = ID_EMPTY;
                    res_key_next   = KEY_ZERO;
                    scan_len_next  = scan_len;
                    issue_cnt_next = '0;
                    best_ctl.clr   = 1'b1;
                    if (mode == MODE_POP)
                    begin
                        state_next = (scan_len == '0) ? ST_DONE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_WR_READ;
                    end
                end
            end
            ST_WR_READ:
            begin
                state_next = slot_ok_reg ? ST_WR_WRITE : ST_DONE;
            end
            ST_WR_WRITE:
            begin
                ram_we = 1'b1;
                if (now_valid && !was_valid && count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (was_valid && !now_valid && count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                ram_addr        = issue_cnt_reg[AW-1:0];
                best_ctl.sample = rd_pend_reg;
                if (issue_cnt_reg != scan_len_reg)
                begin
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = issue_cnt_reg[AW-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = best_have ? ST_POP_WRITE : ST_DONE;
                end
            end
            ST_POP_WRITE:
            begin
                ram_we       = 1'b1;
                ram_addr     = win_idx;
                ram_wdata    = {ID_EMPTY, best_key};
                found_next   = 1'b1;
                res_id_next  = best_id;
                res_key_next = best_key;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            scan_len_reg  <= '0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            count_reg     <= count_next;
            scan_len_reg  <= scan_len_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        slot_reg    <= slot_next;
        slot_ok_reg <= slot_ok_next;
        id_reg      <= id_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        res_id_reg  <= res_id_next;
        res_key_reg <= res_key_next;
    end

    assign cand_idx     = rd_idx_reg;
    assign result.found = found_reg;
    assign result.id    = res_id_reg;
    assign result.key   = res_key_reg;
    assign result.count = COUNT_W'(count_reg);

endmodule

@@ hdl/masked_best_entry_pop.sv @@
// Top level of the masked best entry pop block: configuration, entry memory and output register.
//
// The block keeps a table of MAX_ENTRIES candidates, each a 32-bit id and a 32-bit signed
// ordered key, in one synchronous RAM; an id with its sign bit set marks an empty slot.
// After reset the block runs a clearing pass that marks every slot empty, and it holds
// in_stall high until that pass is done. For a write item (mode 0) the slot is read, then
// rewritten, and the valid count follows the change in that slot's emptiness. For a pop
// item (mode 1) the sequencer reads one slot per cycle through the single RAM port, with
// the scan length taken from entries_in_use and capped at MAX_ENTRIES; a tracker keeps the
// running best key (smallest, or largest when select_largest is set, with the later slot
// winning a tie), and the winner is then written back as empty. There is no write-back
// when no valid entry is found, and no scan at all when the scan length is zero. Items
// are handled one at a time; in_stall is low only while the sequencer is idle, which it
// becomes again as each result is registered. Each item gives exactly one result, held
// in an output register, so a new item is taken while the previous result still waits
// on out_stall. Configuration writes are always ready and must only be issued while no
// item is in flight.
module masked_best_entry_pop #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [5:0]                        slot_index,
    input  logic signed [31:0]                entry_id,
    input  logic signed [31:0]                entry_key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic signed [31:0]                popped_id,
    output logic signed [31:0]                popped_key,
    output logic [6:0]                        valid_entries,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbep_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbep_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import mbep_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [CFG_DAT_W-1:0] entries_in_use_reg;
    logic                 select_largest_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic                 idle;
    logic                 accept;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    best_ctl_t            best_ctl;
    logic [AW-1:0]        cand_idx;
    logic                 best_have;
    logic [AW-1:0]        win_idx;
    logic [DATA_W-1:0]    best_id;
    logic [DATA_W-1:0]    best_key;
    logic                 res_valid;
    result_t              result;
    logic                 res_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = !idle;
    assign accept    = in_valid && idle;

    // The output register frees up when it is empty or its item leaves this cycle.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= 7'd1;
            select_largest_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRIES_IN_USE: entries_in_use_reg <= cfg_data;
                CFG_SELECT_LARGEST: select_largest_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_reg.found;
    assign popped_id     = out_reg.id;
    assign popped_key    = out_reg.key;
    assign valid_entries = out_reg.count;

    // Id in the upper half of each word, key in the lower half.
    mbep_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    mbep_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .mode           (mode),
        .slot_index     (slot_index),
        .entry_id       (entry_id),
        .entry_key      (entry_key),
        .entries_in_use (entries_in_use_reg),
        .idle           (idle),
        .ram_we         (ram_we),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata),
        .ram_rdata      (ram_rdata),
        .best_ctl       (best_ctl),
        .cand_idx       (cand_idx),
        .best_have      (best_have),
        .win_idx        (win_idx),
        .best_id        (best_id),
        .best_key       (best_key),
        .res_valid      (res_valid),
        .result         (result),
        .res_take       (res_take)
    );

    mbep_best #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_best (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (best_ctl),
        .select_largest (select_largest_reg),
        .cand_idx       (cand_idx),
        .cand           (ram_rdata),
        .have           (best_have),
        .win_idx        (win_idx),
        .best_id        (best_id),
        .best_key       (best_key)
    );

endmodule
